[hdl/mdseg_pkg.sv]
`timescale 1ns / 1ps

package mdseg_pkg;

	localparam int CHROM_W  = 8;
	localparam int READ_W   = 16;
	localparam int CLASS_W  = 2;
	localparam int DESERT_W = 32;
	localparam int SUM_W    = 36;

	localparam logic [DESERT_W-1:0] DESERT_RST  = 32'd1000;
	localparam logic [SUM_W-1:0]    MIN_SUM_RST = 36'd262144;
	localparam logic [SUM_W-1:0]    SUM_MAX     = '1;
	localparam logic [CLASS_W-1:0]  CLASS_LOW   = 2'd0;

	typedef enum logic {
		OP_SITE  = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef enum logic {
		CFG_DESERT  = 1'b0,
		CFG_MIN_SUM = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	typedef struct packed {
		logic              start;
		logic [READ_W-1:0] meth;
		logic [READ_W-1:0] total;
	} div_req_t;

endpackage

[hdl/mdseg_if.sv]
`timescale 1ns / 1ps

interface mdseg_site_if import mdseg_pkg::*; #(parameter int POS_BITS = 32);
	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic [CHROM_W-1:0]  chrom_id;
	logic [POS_BITS-1:0] site_start;
	logic [POS_BITS-1:0] site_end;
	logic [CLASS_W-1:0]  site_class;
	logic [READ_W-1:0]   meth_reads;
	logic [READ_W-1:0]   total_reads;

	modport source (output valid, opcode, chrom_id, site_start, site_end, site_class,
		meth_reads, total_reads, input ready);
	modport sink (input valid, opcode, chrom_id, site_start, site_end, site_class,
		meth_reads, total_reads, output ready);
endinterface

interface mdseg_domain_if import mdseg_pkg::*; #(
	parameter int POS_BITS   = 32,
	parameter int COUNT_BITS = 20
);
	logic                  valid;
	logic                  ready;
	logic [CHROM_W-1:0]    domain_chrom;
	logic [POS_BITS-1:0]   domain_start;
	logic [POS_BITS-1:0]   domain_end;
	logic [COUNT_BITS-1:0] site_count;
	logic [SUM_W-1:0]      meth_score;

	modport source (output valid, domain_chrom, domain_start, domain_end, site_count,
		meth_score, input ready);
	modport sink (input valid, domain_chrom, domain_start, domain_end, site_count,
		meth_score, output ready);
endinterface

interface mdseg_cfg_if import mdseg_pkg::*;;
	logic             valid;
	logic             ready;
	cfg_idx_t         idx;
	logic [SUM_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

[hdl/mdseg_div.sv]
`timescale 1ns / 1ps

module mdseg_div import mdseg_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  div_req_t               req,
	output logic                   busy,
	output logic [FRACTION_BITS:0] quot
);

	localparam int CNT_W = $clog2(FRACTION_BITS + 1);

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [READ_W-1:0]      rem_q;
	logic [READ_W-1:0]      total_q;
	logic [FRACTION_BITS:0] quot_q;

	logic [READ_W-1:0] meth_c;
	logic              int_bit;
	logic [READ_W-1:0] rem_init;
	logic [READ_W:0]   rem2;
	logic [READ_W:0]   diff;
	logic              ge;
	logic [READ_W-1:0] rem_nxt;

	always_comb begin
		// excess methylated reads count as full coverage
		meth_c   = (req.meth > req.total) ? req.total : req.meth;
		int_bit  = (meth_c == req.total);
		rem_init = int_bit ? '0 : meth_c;
		rem2     = {rem_q, 1'b0};
		diff     = rem2 - {1'b0, total_q};
		ge       = (rem2 >= {1'b0, total_q});
		rem_nxt  = ge ? diff[READ_W-1:0] : rem2[READ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(FRACTION_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= rem_init;
			total_q <= req.total;
			quot_q  <= {{FRACTION_BITS{1'b0}}, int_bit};
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			quot_q <= {quot_q[FRACTION_BITS-1:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

[hdl/methylation_domain_segmenter.sv]
`timescale 1ns / 1ps

// port     dir  beat
// site     in   one CpG site or a flush, valid/ready
// domain   out  one emitted domain, valid/ready
// cfg      in   register write: idx 0 desert gap limit, idx 1 min_meth_sum
//
// a kept site goes from idle through the divide state to the update state, its
// pace set by the restoring divider that forms one fraction bit per cycle
// a flush goes straight to update, a site with zero total reads stays in idle
// reset clears control, config and run state at once, no clearing pass
// the update step waits while a new domain is due and the previous one is still
// held in the output register; a new site is taken while a domain waits

module methylation_domain_segmenter import mdseg_pkg::*; #(
	parameter int POS_BITS      = 32,
	parameter int FRACTION_BITS = 16,
	parameter int COUNT_BITS    = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	mdseg_site_if.sink     site,
	mdseg_domain_if.source domain,
	mdseg_cfg_if.sink      cfg
);

	localparam int GAP_W = (POS_BITS > DESERT_W) ? POS_BITS : DESERT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t state_q;

	logic [DESERT_W-1:0] desert_q;
	logic [SUM_W-1:0]    min_sum_q;

	opcode_t             op_q;
	logic [CHROM_W-1:0]  chrom_q;
	logic [POS_BITS-1:0] start_q;
	logic [POS_BITS-1:0] end_q;
	logic                high_q;

	logic                  run_open_q;
	logic [CHROM_W-1:0]    last_chrom_q;
	logic [POS_BITS-1:0]   last_start_q;
	logic [POS_BITS-1:0]   last_end_q;
	logic [POS_BITS-1:0]   run_start_q;
	logic                  run_is_high_q;
	logic [COUNT_BITS-1:0] run_count_q;
	logic [SUM_W-1:0]      run_sum_q;

	logic                  out_valid_q;
	logic [CHROM_W-1:0]    dom_chrom_q;
	logic [POS_BITS-1:0]   dom_start_q;
	logic [POS_BITS-1:0]   dom_end_q;
	logic [COUNT_BITS-1:0] dom_count_q;
	logic [SUM_W-1:0]      dom_sum_q;

	div_req_t               div_req;
	logic                   div_busy;
	logic [FRACTION_BITS:0] frac;

	logic                site_acc;
	logic                site_drop;
	logic [POS_BITS-1:0] gap;
	logic                new_seg;
	logic                close_run;
	logic                emit;
	logic                upd_stall;
	logic                upd_go;
	logic [SUM_W:0]      sum_add;
	logic [SUM_W-1:0]    sum_sat;

	assign site.ready = (state_q == ST_IDLE);
	assign site_acc   = site.valid && site.ready;
	assign site_drop  = (site.total_reads == '0);

	assign div_req.start = site_acc && (site.opcode == OP_SITE) && !site_drop;
	assign div_req.meth  = site.meth_reads;
	assign div_req.total = site.total_reads;

	mdseg_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.busy  (div_busy),
		.quot  (frac)
	);

	always_comb begin
		gap       = start_q - last_start_q;
		new_seg   = !run_open_q || (chrom_q != last_chrom_q)
			|| (GAP_W'(gap) > GAP_W'(desert_q));
		close_run = (op_q == OP_FLUSH) || new_seg || (high_q != run_is_high_q);
		emit      = close_run && run_open_q && run_is_high_q && (run_sum_q >= min_sum_q);
		upd_stall = emit && out_valid_q && !domain.ready;
		upd_go    = (state_q == ST_UPD) && !upd_stall;
		sum_add   = {1'b0, run_sum_q} + (SUM_W + 1)'(frac);
		sum_sat   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
	end

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desert_q  <= DESERT_RST;
			min_sum_q <= MIN_SUM_RST;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				CFG_DESERT:  desert_q  <= cfg.data[DESERT_W-1:0];
				CFG_MIN_SUM: min_sum_q <= cfg.data;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (site_acc) begin
						if (site.opcode == OP_FLUSH) begin
							state_q <= ST_UPD;
						end else if (!site_drop) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (!upd_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// held beat fields
	always_ff @(posedge clk) begin
		if (site_acc) begin
			op_q    <= site.opcode;
			chrom_q <= site.chrom_id;
			start_q <= site.site_start;
			end_q   <= site.site_end;
			high_q  <= (site.site_class != CLASS_LOW);
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q    <= 1'b0;
			last_chrom_q  <= '0;
			last_start_q  <= '0;
			last_end_q    <= '0;
			run_start_q   <= '0;
			run_is_high_q <= 1'b0;
			run_count_q   <= '0;
			run_sum_q     <= '0;
		end else if (upd_go) begin
			if (op_q == OP_FLUSH) begin
				run_open_q <= 1'b0;
			end else begin
				if (close_run) begin
					run_open_q    <= 1'b1;
					run_start_q   <= start_q;
					run_is_high_q <= high_q;
					run_count_q   <= COUNT_BITS'(1);
					run_sum_q     <= SUM_W'(frac);
				end else begin
					if (run_count_q != COUNT_MAX) begin
						run_count_q <= run_count_q + 1'b1;
					end
					run_sum_q <= sum_sat;
				end
				last_chrom_q <= chrom_q;
				last_start_q <= start_q;
				last_end_q   <= end_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (domain.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && emit) begin
			dom_chrom_q <= last_chrom_q;
			dom_start_q <= run_start_q;
			dom_end_q   <= last_end_q;
			dom_count_q <= run_count_q;
			dom_sum_q   <= run_sum_q;
		end
	end

	assign domain.valid        = out_valid_q;
	assign domain.domain_chrom = dom_chrom_q;
	assign domain.domain_start = dom_start_q;
	assign domain.domain_end   = dom_end_q;
	assign domain.site_count   = dom_count_q;
	assign domain.meth_score   = dom_sum_q;

	a_flush_upd: assert property (@(posedge clk) disable iff (!arst_n)
		site_acc && (site.opcode == OP_FLUSH) |=> state_q == ST_UPD)
		else $error("flush beat did not go to update");

	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		site_acc && (site.opcode == OP_SITE) && site_drop
		|=> (state_q == ST_IDLE) && $stable(run_open_q) && $stable(run_sum_q))
		else $error("site with no reads changed state");

	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_open_q |-> run_count_q != '0)
		else $error("open run with zero sites");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !domain.ready |=> $stable(dom_sum_q) && $stable(dom_start_q))
		else $error("held domain overwritten");

endmodule
